// ===== src/ssd_pkg.sv =====
package ssd_pkg;

	localparam int CW         = 32;             // input coordinate
	localparam int NCOORD     = 12;
	localparam int IN_W       = NCOORD * CW;    // packed request width
	localparam int DLW        = CW + 1;         // endpoint difference
	localparam int PROD_W     = 2 * DLW;        // one coordinate product
	localparam int DOT_W      = PROD_W + 2;     // three-term dot product
	localparam int HALF_W     = DOT_W / 2;      // multiplier split point
	localparam int PW         = 2 * DOT_W + 2;  // wide product
	localparam int DW         = PW + 2;         // divider datapath
	localparam int PARAM_FRAC = 32;             // fraction bits of s and t
	localparam int QW         = PARAM_FRAC + 1; // s, t including 1.0
	localparam int ROOT_W     = 41;
	localparam int YW         = 2 * ROOT_W + 2;
	localparam int OUT_W      = 33;
	localparam int OUT_TD_W   = ((OUT_W + 7) / 8) * 8;
	localparam int THR_W      = 32;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(4295);
	localparam int QDEPTH     = 8;
	localparam int QAW        = $clog2(QDEPTH);
	localparam int QCW        = $clog2(QDEPTH + 1);

	typedef logic signed [CW-1:0]    crd_t;
	typedef logic signed [DLW-1:0]   dl_t;
	typedef logic signed [DOT_W-1:0] dot_t;

	typedef enum logic [1:0] {
		K_BOTH,   // both segments are points
		K_ADEG,   // first segment is a point
		K_BDEG,   // second segment is a point
		K_GEN     // general case
	} kind_t;

	typedef struct packed {
		crd_t [2:0]      a0;
		crd_t [2:0]      b0;
		dl_t  [2:0]      d1;
		dl_t  [2:0]      d2;
		dot_t            a;
		dot_t            b;
		dot_t            c;
		dot_t            e;
		dot_t            f;
		kind_t           kind;
		logic [QW-1:0]   s;
		logic [QW-1:0]   t;
		logic            tneg;
		logic            tbig;
	} side_t;

	typedef struct packed {
		side_t                 side;
		logic signed [DW-1:0]  num;
		logic signed [DW-1:0]  den;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// partial products of a split multiply
	typedef struct packed {
		logic signed [2*HALF_W-1:0] hh;
		logic signed [2*HALF_W:0]   hl;
		logic signed [2*HALF_W:0]   lh;
		logic [2*HALF_W-1:0]        ll;
	} pp_t;

	function automatic pp_t mul_pp(input dot_t x, input dot_t y);
		pp_t p;
		logic signed [HALF_W-1:0] xh;
		logic signed [HALF_W-1:0] yh;
		logic signed [HALF_W:0]   xl;
		logic signed [HALF_W:0]   yl;
		xh = x[DOT_W-1:HALF_W];
		yh = y[DOT_W-1:HALF_W];
		xl = {1'b0, x[HALF_W-1:0]};
		yl = {1'b0, y[HALF_W-1:0]};
		p.hh = xh * yh;
		p.hl = xh * yl;
		p.lh = xl * yh;
		p.ll = x[HALF_W-1:0] * y[HALF_W-1:0];
		return p;
	endfunction

	function automatic logic signed [PW-1:0] pp_sum(input pp_t p);
		logic signed [PW-1:0] hh;
		logic signed [PW-1:0] mid;
		logic signed [PW-1:0] ll;
		hh  = PW'(p.hh);
		mid = PW'(p.hl) + PW'(p.lh);
		ll  = $signed(PW'(p.ll));
		return (hh <<< (2 * HALF_W)) + (mid <<< HALF_W) + ll;
	endfunction

endpackage

// ===== src/segment_segment_distance_3d.sv =====
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready     tdata: 12 x 32-bit signed Q16.16 endpoints
// m_axis    out  m_axis_tvalid/m_axis_tready     tdata[32:0]: min_distance, Q17.16
// cfg       in   cfg_valid/cfg_ready             cfg_data: degenerate_threshold
//
// One request per cycle sustained while m_axis_tready does not stall the output. Stages: front 5 stages, queue,
// three 33-stage clamped dividers (s, t, reclamped s), 7 product/sum stages, 42-stage root.
// Reset clears all valid state and the queue; threshold returns to 4295.
// A stalled output freezes the back pipeline; the front keeps filling the 8-entry queue
// and drops s_axis_tready only when front plus queue hold 8 requests.
module segment_segment_distance_3d import ssd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// seg_a_start_x/y/z, seg_a_end_x/y/z, seg_b_start_x/y/z, seg_b_end_x/y/z, 32 bits each
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [IN_W-1:0]     s_axis_tdata,
	// min_distance [32:0], zero pad above
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OUT_TD_W-1:0] m_axis_tdata,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [THR_W-1:0]    cfg_data
);

	// threshold on squared segment length, Q32.32
	logic [THR_W-1:0] thr_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	logic     q_push, q_pop;
	q_entry_t q_in, q_head;
	q_stat_t  q_stat;

	// front: differences, dots, case split, s operands
	ssd_front u_front (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.thr(thr_q), .pop(q_pop),
		.push(q_push), .entry(q_in)
	);

	ssd_queue u_queue (
		.clk, .arst_n,
		.push(q_push), .wr_entry(q_in),
		.pop(q_pop), .head(q_head), .stat(q_stat)
	);

	// back: divides, closest points, root
	ssd_back u_back (
		.clk, .arst_n,
		.head_valid(!q_stat.empty), .head(q_head), .pop(q_pop),
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
	);

	// credit scheme must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (!q_stat.full || q_pop))
		else $error("request queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty request queue");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_TD_W-1:OUT_W] == '0))
		else $error("output pad bits set");

endmodule

// ===== src/ssd_div.sv =====
// clamped quotient n/d in [0,1], PARAM_FRAC fraction bits, one bit per stage
module ssd_div import ssd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [DW-1:0] num,
	input  logic signed [DW-1:0] den,
	input  side_t                side_in,
	output logic                 out_valid,
	output logic [QW-1:0]        quo,
	output side_t                side_out
);

	logic                  vld_s  [0:PARAM_FRAC];
	logic signed [DW-1:0]  rem_s  [0:PARAM_FRAC];
	logic signed [DW-1:0]  den_s  [0:PARAM_FRAC];
	logic [PARAM_FRAC-1:0] quo_s  [0:PARAM_FRAC];
	logic                  spec_s [0:PARAM_FRAC];
	logic                  one_s  [0:PARAM_FRAC];
	side_t                 side_s [0:PARAM_FRAC];

	logic n_le0, d_le0;
	assign n_le0 = (num <= 0);
	assign d_le0 = (den <= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			spec_s[0] <= n_le0 | d_le0 | (num >= den);
			one_s[0]  <= !(n_le0 | d_le0);
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= PARAM_FRAC; k++) begin : g_stage
		logic signed [DW-1:0] rem2;
		logic                 ge;
		assign rem2 = rem_s[k-1] <<< 1;
		assign ge   = (rem2 >= den_s[k-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rem2 - den_s[k-1] : rem2;
				den_s[k]  <= den_s[k-1];
				quo_s[k]  <= {quo_s[k-1][PARAM_FRAC-2:0], ge};
				spec_s[k] <= spec_s[k-1];
				one_s[k]  <= one_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[PARAM_FRAC];
	assign quo       = spec_s[PARAM_FRAC] ? {one_s[PARAM_FRAC], {PARAM_FRAC{1'b0}}}
	                                      : {1'b0, quo_s[PARAM_FRAC]};
	assign side_out  = side_s[PARAM_FRAC];

endmodule

// ===== src/ssd_sqrt.sv =====
// floor square root, one result bit per stage
module ssd_sqrt import ssd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [YW-1:0]     y,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root
);

	logic              vld_s  [0:ROOT_W];
	logic [YW-1:0]     rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= y;
			root_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
		localparam int B = ROOT_W - k;
		logic [YW-1:0] trial;
		logic          fit;
		// (2*root + 2^B) * 2^B
		assign trial = (YW'(root_s[k-1]) << (B + 1)) + (YW'(1) << (2 * B));
		assign fit   = (rem_s[k-1] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= fit ? rem_s[k-1] - trial : rem_s[k-1];
				root_s[k] <= root_s[k-1] | (fit ? (ROOT_W'(1) << B) : '0);
			end
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign root      = root_s[ROOT_W];

endmodule

// ===== src/ssd_front.sv =====
// difference vectors, dot products, case split, divider operands
module ssd_front import ssd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,
	input  logic [THR_W-1:0] thr,
	input  logic             pop,
	output logic             push,
	output q_entry_t         entry
);

	logic           acc;
	logic [QCW-1:0] cred_q;

	assign s_axis_tready = (cred_q < QCW'(QDEPTH));
	assign acc           = s_axis_tvalid & s_axis_tready;

	// requests in this pipeline plus those in the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= '0;
		end else begin
			cred_q <= cred_q + QCW'(acc) - QCW'(pop);
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= {acc, v_s1, v_s2, v_s3, v_s4};
		end
	end

	// stage 1: differences
	side_t side_in;
	always_comb begin
		side_in = '0;
		for (int k = 0; k < 3; k++) begin
			side_in.a0[k] = s_axis_tdata[k*CW +: CW];
			side_in.b0[k] = s_axis_tdata[(6+k)*CW +: CW];
			side_in.d1[k] = DLW'($signed(s_axis_tdata[(3+k)*CW +: CW]))
			              - DLW'($signed(s_axis_tdata[k*CW +: CW]));
			side_in.d2[k] = DLW'($signed(s_axis_tdata[(9+k)*CW +: CW]))
			              - DLW'($signed(s_axis_tdata[(6+k)*CW +: CW]));
		end
	end

	side_t side_s1;
	dl_t   r_s1 [3];
	always_ff @(posedge clk) begin
		side_s1 <= side_in;
		for (int k = 0; k < 3; k++) begin
			r_s1[k] <= DLW'($signed(s_axis_tdata[k*CW +: CW]))
			         - DLW'($signed(s_axis_tdata[(6+k)*CW +: CW]));
		end
	end

	// stage 2: coordinate products
	side_t                     side_s2;
	logic signed [PROD_W-1:0]  paa_s2 [3];
	logic signed [PROD_W-1:0]  pee_s2 [3];
	logic signed [PROD_W-1:0]  pff_s2 [3];
	logic signed [PROD_W-1:0]  pcc_s2 [3];
	logic signed [PROD_W-1:0]  pbb_s2 [3];
	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		for (int k = 0; k < 3; k++) begin
			paa_s2[k] <= $signed(side_s1.d1[k]) * $signed(side_s1.d1[k]);
			pee_s2[k] <= $signed(side_s1.d2[k]) * $signed(side_s1.d2[k]);
			pff_s2[k] <= $signed(side_s1.d2[k]) * r_s1[k];
			pcc_s2[k] <= $signed(side_s1.d1[k]) * r_s1[k];
			pbb_s2[k] <= $signed(side_s1.d1[k]) * $signed(side_s1.d2[k]);
		end
	end

	// stage 3: dot products
	side_t side_dot;
	always_comb begin
		side_dot   = side_s2;
		side_dot.a = DOT_W'(paa_s2[0]) + DOT_W'(paa_s2[1]) + DOT_W'(paa_s2[2]);
		side_dot.e = DOT_W'(pee_s2[0]) + DOT_W'(pee_s2[1]) + DOT_W'(pee_s2[2]);
		side_dot.f = DOT_W'(pff_s2[0]) + DOT_W'(pff_s2[1]) + DOT_W'(pff_s2[2]);
		side_dot.c = DOT_W'(pcc_s2[0]) + DOT_W'(pcc_s2[1]) + DOT_W'(pcc_s2[2]);
		side_dot.b = DOT_W'(pbb_s2[0]) + DOT_W'(pbb_s2[1]) + DOT_W'(pbb_s2[2]);
	end

	side_t side_s3;
	always_ff @(posedge clk) begin
		side_s3 <= side_dot;
	end

	// stage 4: classify, split products
	dot_t thr_x;
	logic a_pt, e_pt;
	assign thr_x = $signed({{(DOT_W-THR_W){1'b0}}, thr});
	assign a_pt  = (side_s3.a <= thr_x);
	assign e_pt  = (side_s3.e <= thr_x);

	side_t side_cls;
	always_comb begin
		side_cls = side_s3;
		if (a_pt && e_pt) begin
			side_cls.kind = K_BOTH;
		end else if (a_pt) begin
			side_cls.kind = K_ADEG;
		end else if (e_pt) begin
			side_cls.kind = K_BDEG;
		end else begin
			side_cls.kind = K_GEN;
		end
	end

	side_t side_s4;
	pp_t   ae_s4, bb_s4, bf_s4, ce_s4;
	always_ff @(posedge clk) begin
		side_s4 <= side_cls;
		ae_s4   <= mul_pp(side_s3.a, side_s3.e);
		bb_s4   <= mul_pp(side_s3.b, side_s3.b);
		bf_s4   <= mul_pp(side_s3.b, side_s3.f);
		ce_s4   <= mul_pp(side_s3.c, side_s3.e);
	end

	// stage 5: full products
	side_t                side_s5;
	logic signed [PW-1:0] ae_s5, bb_s5, bf_s5, ce_s5;
	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		ae_s5   <= pp_sum(ae_s4);
		bb_s5   <= pp_sum(bb_s4);
		bf_s5   <= pp_sum(bf_s4);
		ce_s5   <= pp_sum(ce_s4);
	end

	// operands for the s quotient; a zero numerator gives s = 0
	always_comb begin
		entry.side = side_s5;
		entry.num  = '0;
		entry.den  = '0;
		case (side_s5.kind)
			K_GEN: begin
				entry.num = DW'(bf_s5) - DW'(ce_s5);
				entry.den = DW'(ae_s5) - DW'(bb_s5);
			end
			K_BDEG: begin
				entry.num = -DW'(side_s5.c);
				entry.den = DW'(side_s5.a);
			end
			default: begin
				entry.num = '0;
				entry.den = '0;
			end
		endcase
	end

	assign push = v_s5;

endmodule

// ===== src/ssd_queue.sv =====
// request queue between front and back
module ssd_queue import ssd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wr_entry,
	input  logic     pop,
	output q_entry_t head,
	output q_stat_t  stat
);

	q_entry_t       mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QCW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			cnt_q <= cnt_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_entry;
		end
	end

	assign head       = mem_q[rd_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == QCW'(QDEPTH));

endmodule

// ===== src/ssd_back.sv =====
// s, t, reclamp, closest points, squared distance, root
module ssd_back import ssd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  q_entry_t            head,
	output logic                pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OUT_TD_W-1:0] m_axis_tdata
);

	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign pop = adv && head_valid;

	// s
	logic          v1;
	logic [QW-1:0] q1;
	side_t         side1;
	ssd_div u_div_s (
		.clk, .arst_n, .en(adv), .in_valid(head_valid),
		.num(head.num), .den(head.den), .side_in(head.side),
		.out_valid(v1), .quo(q1), .side_out(side1)
	);

	// t numerator b*s + f*2^32
	side_t side_sel;
	always_comb begin
		side_sel   = side1;
		side_sel.s = q1;
	end

	logic v_s1, v_s2;
	side_t side_s1, side_s2;
	pp_t   bs_s1;
	logic signed [PW-1:0] tn_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v1;
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_sel;
			bs_s1   <= mul_pp(side1.b, $signed(DOT_W'(q1)));
			side_s2 <= side_s1;
			tn_s2   <= pp_sum(bs_s1) + (PW'(side_s1.f) <<< PARAM_FRAC);
		end
	end

	logic signed [DW-1:0] tn, td, n2, d2;
	side_t side2_in;
	assign tn = DW'(tn_s2);
	assign td = DW'(side_s2.e) <<< PARAM_FRAC;
	always_comb begin
		side2_in      = side_s2;
		side2_in.tneg = (tn < 0);
		side2_in.tbig = (tn > td);
		case (side_s2.kind)
			K_GEN: begin
				n2 = tn;
				d2 = td;
			end
			K_ADEG: begin
				n2 = DW'(side_s2.f);
				d2 = DW'(side_s2.e);
			end
			default: begin
				n2 = '0;
				d2 = '0;
			end
		endcase
	end

	logic          v2;
	logic [QW-1:0] q2;
	side_t         side2;
	ssd_div u_div_t (
		.clk, .arst_n, .en(adv), .in_valid(v_s2),
		.num(n2), .den(d2), .side_in(side2_in),
		.out_valid(v2), .quo(q2), .side_out(side2)
	);

	// t out of range: pin t, recompute s
	logic signed [DW-1:0] n3;
	side_t side3_in;
	always_comb begin
		side3_in   = side2;
		side3_in.t = q2;
		n3 = side2.tbig ? DW'(side2.b) - DW'(side2.c) : -DW'(side2.c);
	end

	logic          v3;
	logic [QW-1:0] q3;
	side_t         side3;
	ssd_div u_div_r (
		.clk, .arst_n, .en(adv), .in_valid(v2),
		.num(n3), .den(DW'(side2.a)), .side_in(side3_in),
		.out_valid(v3), .quo(q3), .side_out(side3)
	);

	logic          redo;
	logic [QW-1:0] s_fin;
	assign redo  = (side3.kind == K_GEN) && (side3.tneg || side3.tbig);
	assign s_fin = redo ? q3 : side3.s;

	// closest points and squared distance
	logic v_s3, v_s4, v_s5, v_s6, v_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (adv) begin
			{v_s3, v_s4, v_s5, v_s6, v_s7} <= {v3, v_s3, v_s4, v_s5, v_s6};
		end
	end

	crd_t a0_s3 [3];
	crd_t b0_s3 [3];
	dot_t ms_s3 [3];
	dot_t mt_s3 [3];
	dot_t df_s4 [3];
	pp_t  sq_s5 [3];
	logic signed [PW-1:0] sq_s6 [3];
	logic [YW-1:0]        y_s7;
	logic signed [PW-1:0] sq_sum;

	assign sq_sum = sq_s6[0] + sq_s6[1] + sq_s6[2];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				a0_s3[k] <= side3.a0[k];
				b0_s3[k] <= side3.b0[k];
				ms_s3[k] <= $signed(side3.d1[k]) * $signed({1'b0, s_fin});
				mt_s3[k] <= $signed(side3.d2[k]) * $signed({1'b0, side3.t});
				df_s4[k] <= ($signed({a0_s3[k], {PARAM_FRAC{1'b0}}}) + ms_s3[k])
				          - ($signed({b0_s3[k], {PARAM_FRAC{1'b0}}}) + mt_s3[k]);
				sq_s5[k] <= mul_pp(df_s4[k], df_s4[k]);
				sq_s6[k] <= pp_sum(sq_s5[k]);
			end
			y_s7 <= YW'(sq_sum[PW-1:2*PARAM_FRAC]);
		end
	end

	logic              v_out;
	logic [ROOT_W-1:0] root;
	ssd_sqrt u_sqrt (
		.clk, .arst_n, .en(adv), .in_valid(v_s7), .y(y_s7),
		.out_valid(v_out), .root(root)
	);

	logic [OUT_W-1:0] min_dist;
	assign min_dist = (root > ROOT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : root[OUT_W-1:0];

	assign m_axis_tvalid = v_out;
	assign m_axis_tdata  = OUT_TD_W'(min_dist);

endmodule

// ===== test/segment_segment_distance_3d_test.sv =====
`timescale 1ns / 100ps

// Checks the segment to segment distance block against a predictor that works in
// exact wide integers. Requests go in as streamed items and every result is compared
// with the oldest expected distance. The threshold register is rewritten between
// phases, only while the block is idle.
module segment_segment_distance_3d_test;
	import ssd_pkg::*;

	typedef logic signed [255:0] wide_t;
	typedef logic [IN_W-1:0] req_t;

	localparam int SETTLE_CYCLES = 200;   // a bit more than the pipeline latency
	localparam int CYCLE_LIMIT   = 600000;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata;    // a start xyz, a end xyz, b start xyz, b end xyz
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_TD_W-1:0] m_axis_tdata;    // min_distance [32:0], zero pad above
	logic                cfg_valid;
	logic                cfg_ready;
	logic [THR_W-1:0]    cfg_data;

	logic [THR_W-1:0] point_threshold;    // predictor copy of the register
	logic [OUT_W-1:0] expected_dist[$];
	int               mismatches;
	int               cycle_count;
	int               send_idle_pct;      // chance in percent of a gap before a request
	int               recv_idle_pct;      // chance in percent of a stalled cycle

	segment_segment_distance_3d i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// clamp n/d into [0,1] with 32 fraction bits, truncating
	function automatic wide_t clamp_ratio(input wide_t n, input wide_t d);
		if (d <= 0 || n <= 0)
			return 0;
		if (n >= d)
			return wide_t'(1) <<< PARAM_FRAC;
		return (n <<< PARAM_FRAC) / d;
	endfunction

	function automatic wide_t dot3(input wide_t p[3], input wide_t q[3]);
		return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
	endfunction

	function automatic logic [OUT_W-1:0] segment_distance(input req_t r,
			input logic [THR_W-1:0] thr);
		wide_t a0[3], b0[3], d1[3], d2[3], rv[3];
		wide_t a, b, c, e, f, thr_w, den, tn, td, s, t, pa, pb, df, sq, y, root, cand;
		a = 0;
		for (int k = 0; k < 3; k++) begin
			a0[k] = $signed(r[k*CW +: CW]);
			d1[k] = wide_t'($signed(r[(3+k)*CW +: CW])) - a0[k];
			b0[k] = $signed(r[(6+k)*CW +: CW]);
			d2[k] = wide_t'($signed(r[(9+k)*CW +: CW])) - b0[k];
			rv[k] = a0[k] - b0[k];
		end
		a = dot3(d1, d1);
		e = dot3(d2, d2);
		f = dot3(d2, rv);
		c = dot3(d1, rv);
		b = dot3(d1, d2);
		thr_w = wide_t'({1'b0, thr});
		s = 0;
		t = 0;
		if (a <= thr_w && e <= thr_w) begin
			s = 0;
		end else if (a <= thr_w) begin
			t = clamp_ratio(f, e);
		end else if (e <= thr_w) begin
			s = clamp_ratio(-c, a);
		end else begin
			den = a * e - b * b;
			if (den != 0)
				s = clamp_ratio(b * f - c * e, den);
			tn = b * s + (f <<< PARAM_FRAC);
			td = e <<< PARAM_FRAC;
			if (tn < 0) begin
				t = 0;
				s = clamp_ratio(-c, a);
			end else if (tn > td) begin
				t = wide_t'(1) <<< PARAM_FRAC;
				s = clamp_ratio(b - c, a);
			end else begin
				t = clamp_ratio(tn, td);
			end
		end
		sq = 0;
		for (int k = 0; k < 3; k++) begin
			pa = (a0[k] <<< PARAM_FRAC) + d1[k] * s;
			pb = (b0[k] <<< PARAM_FRAC) + d2[k] * t;
			df = pa - pb;
			sq = sq + df * df;
		end
		y = sq >>> (2 * PARAM_FRAC);
		root = 0;
		for (int bt = ROOT_W - 1; bt >= 0; bt--) begin
			cand = root | (wide_t'(1) <<< bt);
			if (cand * cand <= y)
				root = cand;
		end
		if (root > wide_t'(34'h1_FFFF_FFFF))
			root = wide_t'(34'h1_FFFF_FFFF);
		return root[OUT_W-1:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// prediction at request acceptance, comparison at result acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_dist.push_back(segment_distance(s_axis_tdata, point_threshold));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_dist.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
				end else begin
					if (m_axis_tdata[OUT_W-1:0] !== expected_dist[0])
						report_mismatch($sformatf("min_distance %h, expected %h",
							m_axis_tdata[OUT_W-1:0], expected_dist[0]));
					if (m_axis_tdata[OUT_TD_W-1:OUT_W] !== '0)
						report_mismatch("nonzero pad bits");
					void'(expected_dist.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_request(input req_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= r;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// wait for every outstanding result, then let the pipeline settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_dist.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		point_threshold = v;
	endtask

	function automatic req_t pack_points(input logic [CW-1:0] p[12]);
		req_t r;
		for (int k = 0; k < 12; k++)
			r[k*CW +: CW] = p[k];
		return r;
	endfunction

	function automatic logic [CW-1:0] small_coord();
		return CW'($signed($urandom_range(16 << 16)) - (8 << 16));
	endfunction

	// mostly well-formed geometry with random content, some raw noise
	function automatic req_t random_request();
		logic [CW-1:0] p[12];
		int mode;
		int kk;
		mode = $urandom_range(9);
		for (int k = 0; k < 12; k++)
			p[k] = (mode < 3) ? $urandom() : small_coord();
		case (mode)
			4: for (int k = 0; k < 3; k++) p[3+k] = p[k] + $urandom_range(1);   // A a point
			5: for (int k = 0; k < 3; k++) p[9+k] = p[6+k] + $urandom_range(1); // B a point
			6: begin // parallel: B direction an integer multiple of A direction
				kk = $urandom_range(4) - 2;
				for (int k = 0; k < 3; k++)
					p[9+k] = p[6+k] + (p[3+k] - p[k]) * kk;
			end
			7: for (int k = 0; k < 3; k++) begin // both points
				p[3+k] = p[k];
				p[9+k] = p[6+k];
			end
			default: ;
		endcase
		return pack_points(p);
	endfunction

	task automatic test_directed();
		logic [CW-1:0] p[12];
		for (int k = 0; k < 12; k++) p[k] = 32'h7FFF_FFFF;
		send_request(pack_points(p));
		for (int k = 0; k < 12; k++) p[k] = (k < 6) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		send_request(pack_points(p));
		for (int k = 0; k < 12; k++) p[k] = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		send_request(pack_points(p));
		for (int k = 0; k < 12; k++) p[k] = ((k / 3) % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		send_request(pack_points(p));
		for (int k = 0; k < 12; k++) p[k] = '0;
		send_request(pack_points(p));                          // all zero
		p[9] = 32'h0001_0000;
		send_request(pack_points(p));                          // A a point on B
		p = '{0, 0, 0, 32'h0002_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 32'hFFFF_0000, 0};
		send_request(pack_points(p));                          // crossing segments
		p = '{0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 32'h0002_0000,
			32'h0001_0000, 0};
		send_request(pack_points(p));                          // parallel
		p = '{0, 0, 0, 32'h0001_0000, 0, 0, 32'h0005_0000, 32'h0001_0000, 0,
			32'h0009_0000, 32'h0001_0000, 0};
		send_request(pack_points(p));                          // parallel and offset, t below zero
		p = '{0, 0, 0, 32'h0001_0000, 0, 0, 32'hFFFB_0000, 32'h0001_0000, 0,
			32'hFFF0_0000, 32'h0003_0000, 0};
		send_request(pack_points(p));                          // t below zero
		p = '{0, 0, 0, 32'h0001_0000, 0, 0, 32'h0000_8000, 32'h0003_0000, 32'h0001_0000,
			32'h0000_8000, 32'h0003_0000, 32'h0001_0000};
		send_request(pack_points(p));                          // B a point
		p = '{5, 7, 9, 5, 7, 9, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000,
			32'h7FFF_FFFF, 32'hFFFF_FFFF};
		send_request(pack_points(p));                          // A a point, long B
		p = '{0, 0, 0, 64, 0, 0, 3, 0, 0, 3, 64, 0};
		send_request(pack_points(p));                          // lengths near threshold
		for (int k = 0; k < 12; k++) p[k] = $urandom();
		send_request(pack_points(p));
		wait_idle();
	endtask

	task automatic test_thresholds();
		logic [THR_W-1:0] levels[4];
		levels = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, THR_RESET};
		foreach (levels[i]) begin
			write_threshold(levels[i]);
			repeat (40) send_request(random_request());
			wait_idle();
		end
	endtask

	// sender holds off until the block has drained, several times
	task automatic test_drain_pause();
		repeat (4) begin
			repeat (10) send_request(random_request());
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while (expected_dist.size() != 0)
				@(posedge clk);
		end
		wait_idle();
	endtask

	task automatic test_random_stream();
		write_threshold($urandom());
		repeat (300) send_request(random_request());
		// full rate on both sides for a while
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (150) send_request(random_request());
		send_idle_pct = 32;
		recv_idle_pct = 32;
		wait_idle();
		write_threshold(THR_RESET);
		repeat (200) send_request(random_request());
		wait_idle();
	endtask

	initial begin
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		m_axis_tready   = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		point_threshold = THR_RESET;
		mismatches      = 0;
		cycle_count     = 0;
		send_idle_pct   = 32;
		recv_idle_pct   = 32;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_thresholds();
		test_drain_pause();
		test_random_stream();

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/ssd_pkg.sv
src/ssd_div.sv
src/ssd_sqrt.sv
src/ssd_front.sv
src/ssd_queue.sv
src/ssd_back.sv
src/segment_segment_distance_3d.sv
test/segment_segment_distance_3d_test.sv
